// File: hw/rtl/dcff_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the feed-forward motor drive.
package dcff_pkg;

	// input word
	typedef struct packed {
		logic [1:0]         mode;
		logic               side;
		logic signed [15:0] tilt_angle;
		logic signed [15:0] wheel_speed;
		logic signed [23:0] accel_demand;
	} in_t;

	// result word
	typedef struct packed {
		logic               kind;
		logic               motor_side;
		logic               in_a;
		logic               in_b;
		logic               pwm_on;
		logic [19:0]        duty_count;
		logic               standby_high;
		logic               brake_all;
		logic               feedback_valid;
		logic signed [23:0] accel_used;
		logic signed [15:0] duty_percent;
		logic signed [23:0] drive_volts;
	} out_t;

	typedef struct packed {
		logic [14:0] tilt_limit;
		logic [22:0] accel_limit;
		logic [31:0] accel_gain;
		logic [31:0] speed_gain;
		logic [15:0] bus_voltage;
	} cfg_t;

	// input word kinds
	localparam logic [1:0] MODE_TILT   = 2'd0;
	localparam logic [1:0] MODE_SPEED  = 2'd1;
	localparam logic [1:0] MODE_DEMAND = 2'd2;

	// result kinds
	localparam logic KIND_TILT  = 1'b0;
	localparam logic KIND_DRIVE = 1'b1;

	// register indexes
	localparam logic [2:0] REG_TILT_LIMIT  = 3'd0;
	localparam logic [2:0] REG_ACCEL_LIMIT = 3'd1;
	localparam logic [2:0] REG_ACCEL_GAIN  = 3'd2;
	localparam logic [2:0] REG_SPEED_GAIN  = 3'd3;
	localparam logic [2:0] REG_BUS_VOLTAGE = 3'd4;

	localparam logic [14:0] RST_TILT_LIMIT  = 15'd5719;
	localparam logic [22:0] RST_ACCEL_LIMIT = 23'd128000;
	localparam logic [31:0] RST_ACCEL_GAIN  = 32'd296454;
	localparam logic [31:0] RST_SPEED_GAIN  = 32'd31104959;
	localparam logic [15:0] RST_BUS_VOLTAGE = 16'd3072;

	// duty scaling: base + round(span * |V| / (bus << 24))
	localparam logic [19:0] DUTY_BASE  = 20'd100000;
	localparam logic [19:0] DUTY_SPAN  = 20'd900000;
	localparam logic [15:0] PCT_BASE   = 16'd2560;
	localparam logic [19:0] PCT_SPAN   = 20'd23040;
	localparam int          DUTY_QBITS = 20;
	localparam int          PCT_QBITS  = 15;

	localparam logic [24:0] VOLTS_POS_MAX = 25'd8388607;
	localparam logic [24:0] VOLTS_NEG_MAX = 25'd8388608;

	// shared multiplier operand selection
	typedef enum logic [1:0] {
		MS_AGAIN = 2'd0,
		MS_SGAIN = 2'd1,
		MS_MLO   = 2'd2,
		MS_MHI   = 2'd3
	} msel_t;

	typedef struct packed {
		logic  capture;
		logic  decode;
		logic  mul;
		logic  acc;
		msel_t msel;
		logic  pct;
		logic  clamp;
		logic  div_step;
		logic  take;
		logic  push;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       over;
		logic       estop;
		logic       vzero;
		logic       out_full;
	} stat_t;

endpackage

// File: hw/rtl/dc_motor_feedforward_pwm_drive.sv
`timescale 1ns / 1ps
// Top level: two-motor feed-forward PWM drive with tilt emergency stop.
// One word is processed at a time. A speed word, an unused-mode word or a tilt that gives
// no status goes back to idle after decode; a tilt that gives a status and a demand during
// stop go from decode to the output state, and a demand with zero voltage ends after the
// clamp. A driving demand uses one 33x25 multiplier six times, and one restoring divider
// gives a 20-bit duty quotient and then a 15-bit percent quotient,
// one bit per cycle. A word with a result also waits while the output register still
// holds an unread word. Results sit in that register, so a finished result waits
// there while the next word is taken. Configuration writes land at once, no wait.
module dc_motor_feedforward_pwm_drive import dcff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	dcff_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dcff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	dcff_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg       (cfg),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hw/rtl/dcff_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register bank with write-only access.
module dcff_cfg_regs import dcff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_limit  <= RST_TILT_LIMIT;
			cfg_q.accel_limit <= RST_ACCEL_LIMIT;
			cfg_q.accel_gain  <= RST_ACCEL_GAIN;
			cfg_q.speed_gain  <= RST_SPEED_GAIN;
			cfg_q.bus_voltage <= RST_BUS_VOLTAGE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILT_LIMIT:  cfg_q.tilt_limit  <= cfg_wdata[14:0];
				REG_ACCEL_LIMIT: cfg_q.accel_limit <= cfg_wdata[22:0];
				REG_ACCEL_GAIN:  cfg_q.accel_gain  <= cfg_wdata;
				REG_SPEED_GAIN:  cfg_q.speed_gain  <= cfg_wdata;
				REG_BUS_VOLTAGE: cfg_q.bus_voltage <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/dcff_datapath.sv
`timescale 1ns / 1ps
// Datapath: state, shared multiplier, clamp, restoring divider and result register.
module dcff_datapath import dcff_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  in_t   in_data,
	input  cfg_t  cfg,
	input  cmd_t  cmd,
	output stat_t st,
	output logic  out_valid,
	input  logic  out_ready,
	output out_t  out_data
);

	in_t                item_q;
	logic signed [23:0] a_q;
	logic               over_q;
	logic               estop_q;
	logic [15:0]        speed_q [2];
	logic signed [57:0] prod_s1;
	logic signed [57:0] acc_q;
	logic               neg_q;
	logic [39:0]        mag_q;
	logic               vzero_q;
	logic signed [23:0] volts_q;
	logic [59:0]        div_rem_q;
	logic [59:0]        div_d_q;
	logic [19:0]        quot_q;
	logic [19:0]        duty_q;
	logic signed [15:0] pct_q;
	out_t               out_q;
	logic               out_valid_q;

	logic [16:0]        tilt_mag;
	logic               over;
	logic [24:0]        dem25, lim25, nlim25;
	logic [23:0]        a_clip;
	logic [15:0]        spd;
	logic [19:0]        kconst;
	logic [32:0]        opa;
	logic [24:0]        opb;
	logic signed [57:0] prod_c;
	logic [57:0]        half_den58, vbus58, absv;
	logic [39:0]        mag_c;
	logic [39:0]        den40;
	logic [59:0]        den_sh;
	logic               ge;
	logic [40:0]        vr;
	logic [24:0]        vu, vsat, vneg;
	logic [15:0]        pct_mag;
	out_t               res;

	// tilt magnitude, -32768 included
	assign tilt_mag = item_q.tilt_angle[15]
		? (17'd0 - {item_q.tilt_angle[15], item_q.tilt_angle})
		: {1'b0, item_q.tilt_angle};
	assign over = tilt_mag > {2'd0, cfg.tilt_limit};

	assign dem25  = {item_q.accel_demand[23], item_q.accel_demand};
	assign lim25  = {2'd0, cfg.accel_limit};
	assign nlim25 = 25'd0 - lim25;

	always_comb begin
		if ($signed(dem25) > $signed(lim25))
			a_clip = lim25[23:0];
		else if ($signed(dem25) < $signed(nlim25))
			a_clip = nlim25[23:0];
		else
			a_clip = dem25[23:0];
	end

	assign spd    = speed_q[item_q.side];
	assign kconst = cmd.pct ? PCT_SPAN : DUTY_SPAN;

	always_comb begin
		case (cmd.msel)
			MS_AGAIN: begin
				opa = {1'b0, cfg.accel_gain};
				opb = {a_q[23], a_q};
			end
			MS_SGAIN: begin
				opa = {1'b0, cfg.speed_gain};
				opb = {{9{spd[15]}}, spd};
			end
			MS_MLO: begin
				opa = {13'd0, kconst};
				opb = {5'd0, mag_q[19:0]};
			end
			MS_MHI: begin
				opa = {13'd0, kconst};
				opb = {5'd0, mag_q[39:20]};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod_c = $signed(opa) * $signed(opb);

	assign half_den58 = {19'd0, cfg.bus_voltage, 23'd0};
	assign vbus58     = {18'd0, cfg.bus_voltage, 24'd0};
	assign absv       = acc_q[57] ? (58'd0 - acc_q) : acc_q;
	assign mag_c      = (absv > vbus58) ? vbus58[39:0] : absv[39:0];

	assign den40  = {cfg.bus_voltage, 24'd0};
	assign den_sh = cmd.pct ? ({20'd0, den40} << (PCT_QBITS - 1))
	                        : ({20'd0, den40} << (DUTY_QBITS - 1));
	assign ge     = div_rem_q >= div_d_q;

	// reported voltage, Q.32 to Q8.16 with rounding and saturation
	assign vr   = {1'b0, mag_q} + 41'd32768;
	assign vu   = vr[40:16];
	assign vsat = neg_q ? ((vu > VOLTS_NEG_MAX) ? VOLTS_NEG_MAX : vu)
	                    : ((vu > VOLTS_POS_MAX) ? VOLTS_POS_MAX : vu);
	assign vneg = 25'd0 - vsat;

	assign pct_mag = PCT_BASE + {1'b0, quot_q[14:0]};

	always_comb begin
		res = '0;
		if (item_q.mode == MODE_TILT) begin
			res.kind         = KIND_TILT;
			res.standby_high = ~over_q;
			res.brake_all    = over_q;
		end else begin
			res.kind         = KIND_DRIVE;
			res.motor_side   = item_q.side;
			res.standby_high = ~estop_q;
			if (!estop_q && !vzero_q) begin
				res.in_a           = ~neg_q;
				res.in_b           = neg_q;
				res.pwm_on         = 1'b1;
				res.duty_count     = duty_q;
				res.feedback_valid = 1'b1;
				res.accel_used     = a_q;
				res.duty_percent   = pct_q;
				res.drive_volts    = volts_q;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estop_q     <= 1'b0;
			speed_q[0]  <= '0;
			speed_q[1]  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decode && item_q.mode == MODE_TILT) begin
				if (over)
					estop_q <= 1'b1;
				else
					estop_q <= 1'b0;
			end
			if (cmd.decode && item_q.mode == MODE_SPEED)
				speed_q[item_q.side] <= item_q.wheel_speed;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= in_data;
		if (cmd.decode) begin
			a_q    <= a_clip;
			over_q <= over;
		end
		if (cmd.mul)
			prod_s1 <= prod_c;
		if (cmd.acc) begin
			case (cmd.msel)
				MS_AGAIN: acc_q <= prod_s1;
				MS_SGAIN: acc_q <= acc_q + prod_s1;
				MS_MLO:   acc_q <= prod_s1 + $signed(half_den58);
				MS_MHI: begin
					// low partial plus half divisor sits in acc_q
					div_rem_q <= {19'd0, acc_q[40:0]} + {prod_s1[39:0], 20'd0};
					div_d_q   <= den_sh;
					quot_q    <= '0;
				end
				default: ;
			endcase
		end
		if (cmd.clamp) begin
			neg_q   <= acc_q[57];
			mag_q   <= mag_c;
			vzero_q <= st.vzero;
		end
		volts_q <= neg_q ? vneg[23:0] : vsat[23:0];
		if (cmd.div_step) begin
			if (ge)
				div_rem_q <= div_rem_q - div_d_q;
			quot_q  <= {quot_q[18:0], ge};
			div_d_q <= div_d_q >> 1;
		end
		if (cmd.take) begin
			if (cmd.pct)
				pct_q <= neg_q ? (16'd0 - pct_mag) : pct_mag;
			else
				duty_q <= DUTY_BASE + quot_q;
		end
		if (cmd.push)
			out_q <= res;
	end

	assign st.mode     = item_q.mode;
	assign st.over     = over;
	assign st.estop    = estop_q;
	assign st.vzero    = (acc_q == '0) || (cfg.bus_voltage == '0);
	assign st.out_full = out_valid_q & ~out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.feedback_valid |->
			out_q.duty_count >= DUTY_BASE && out_q.duty_count <= 20'd1000000)
		else $error("drive duty outside 10 to 100 percent");

	a_estop_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decode && item_q.mode == MODE_TILT && over |=> estop_q)
		else $error("over-limit tilt did not latch the stop");

	a_tilt_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_TILT |->
			out_q.standby_high != out_q.brake_all && !out_q.pwm_on)
		else $error("tilt status word inconsistent");

endmodule

// File: hw/rtl/dcff_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: decodes each input word and steps the shared multiplier, clamp and divider for demand words.
module dcff_ctrl import dcff_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_MUL    = 8'b0000_0100,
		S_ACC    = 8'b0000_1000,
		S_CLAMP  = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_TAKE   = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	localparam logic [4:0] DUTY_LAST = 5'(DUTY_QBITS - 1);
	localparam logic [4:0] PCT_LAST  = 5'(PCT_QBITS - 1);

	state_t     state_q, state_d;
	msel_t      msel_q, msel_d;
	logic       pass_q, pass_d;
	logic [4:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		msel_d  = msel_q;
		pass_d  = pass_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.msel = msel_q;
		cmd.pct  = pass_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				case (st.mode)
					MODE_TILT:  state_d = (st.over || st.estop) ? S_OUT : S_IDLE;
					MODE_SPEED: state_d = S_IDLE;
					MODE_DEMAND: begin
						if (st.estop) begin
							state_d = S_OUT;
						end else begin
							msel_d  = MS_AGAIN;
							state_d = S_MUL;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				case (msel_q)
					MS_AGAIN: begin
						msel_d  = MS_SGAIN;
						state_d = S_MUL;
					end
					MS_SGAIN: state_d = S_CLAMP;
					MS_MLO: begin
						msel_d  = MS_MHI;
						state_d = S_MUL;
					end
					MS_MHI: begin
						cnt_d   = pass_q ? PCT_LAST : DUTY_LAST;
						state_d = S_DIV;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				if (st.vzero) begin
					state_d = S_OUT;
				end else begin
					msel_d  = MS_MLO;
					pass_d  = 1'b0;
					state_d = S_MUL;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0)
					state_d = S_TAKE;
				else
					cnt_d = cnt_q - 5'd1;
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				if (pass_q) begin
					state_d = S_OUT;
				end else begin
					// second pass: percent quotient
					pass_d  = 1'b1;
					msel_d  = MS_MLO;
					state_d = S_MUL;
				end
			end
			S_OUT: begin
				if (!st.out_full) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			msel_q  <= MS_AGAIN;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			msel_q  <= msel_d;
			pass_q  <= pass_d;
			cnt_q   <= cnt_d;
		end
	end

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in progress");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> state_q == S_OUT && !st.out_full)
		else $error("result pushed over an unread word");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

endmodule

// File: tb/dc_motor_feedforward_pwm_drive_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-motor feed-forward PWM drive, random and directed words.
module dc_motor_feedforward_pwm_drive_test;
	import dcff_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int STUCK_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 400;

	typedef enum logic [1:0] {
		RX_FREE   = 2'd0,
		RX_MOSTLY = 2'd1,
		RX_SPARSE = 2'd2,
		RX_BURSTY = 2'd3
	} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	dc_motor_feedforward_pwm_drive uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// drive model: register copies and state
	longint             m_tilt_lim, m_accel_lim, m_accel_gain, m_speed_gain, m_bus;
	logic signed [15:0] held_speed [2];
	bit                 stopped;

	in_t  feed [$];
	out_t drive_due [$];
	int   words_fed = 0;
	int   words_in = 0;
	int   faults = 0;
	int   stuck = 0;
	bit   in_took = 1'b0;

	int        burst_left = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        style_left = 0;
	int        hold_at = 200;
	rx_style_t style = RX_FREE;

	// expected result of one word; updates the model state
	function automatic bit drive_response(input in_t w, output out_t r);
		longint t, a, spd, v, vbus, mag, volts, pct, duty;
		bit     neg;
		r = '0;
		case (w.mode)
		MODE_TILT: begin
			t = longint'(w.tilt_angle);
			if (t < 0) t = -t;
			r.kind = KIND_TILT;
			if (t > m_tilt_lim) begin
				stopped = 1'b1;
				r.brake_all = 1'b1;
				return 1'b1;
			end
			if (stopped) begin
				stopped = 1'b0;
				r.standby_high = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		MODE_SPEED: begin
			held_speed[w.side] = w.wheel_speed;
			return 1'b0;
		end
		MODE_DEMAND: begin
			r.kind = KIND_DRIVE;
			r.motor_side = w.side;
			r.standby_high = !stopped;
			if (stopped) return 1'b1;
			a = longint'(w.accel_demand);
			if (a > m_accel_lim) a = m_accel_lim;
			if (a < -m_accel_lim) a = -m_accel_lim;
			spd = longint'(held_speed[w.side]);
			v = m_accel_gain * a + m_speed_gain * spd;
			vbus = m_bus << 24;
			if (v > vbus) v = vbus;
			if (v < -vbus) v = -vbus;
			if (v == 0) return 1'b1;
			neg = v < 0;
			mag = neg ? -v : v;
			volts = (mag + 32768) >> 16;
			if (neg && volts > longint'(VOLTS_NEG_MAX)) volts = longint'(VOLTS_NEG_MAX);
			if (!neg && volts > longint'(VOLTS_POS_MAX)) volts = longint'(VOLTS_POS_MAX);
			pct = longint'(PCT_BASE) + (longint'(PCT_SPAN) * mag + vbus / 2) / vbus;
			duty = longint'(DUTY_BASE) + (longint'(DUTY_SPAN) * mag + vbus / 2) / vbus;
			if (neg) begin
				pct = -pct;
				volts = -volts;
			end
			r.in_a = !neg;
			r.in_b = neg;
			r.pwm_on = 1'b1;
			r.duty_count = duty[19:0];
			r.feedback_valid = 1'b1;
			r.accel_used = a[23:0];
			r.duty_percent = pct[15:0];
			r.drive_volts = volts[23:0];
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	function automatic bit words_match(input out_t g, input out_t e);
		return g.kind === e.kind && g.motor_side === e.motor_side && g.in_a === e.in_a
			&& g.in_b === e.in_b && g.pwm_on === e.pwm_on && g.duty_count === e.duty_count
			&& g.standby_high === e.standby_high && g.brake_all === e.brake_all
			&& g.feedback_valid === e.feedback_valid && g.accel_used === e.accel_used
			&& g.duty_percent === e.duty_percent && g.drive_volts === e.drive_volts;
	endfunction

	function automatic string show(input out_t w);
		return $sformatf({"kind=%0d side=%0d a=%0d b=%0d pwm=%0d duty=%0d stby=%0d brk=%0d",
			" fb=%0d acc=%0d pct=%0d volts=%0d"}, w.kind, w.motor_side, w.in_a, w.in_b,
			w.pwm_on, w.duty_count, w.standby_high, w.brake_all, w.feedback_valid,
			w.accel_used, w.duty_percent, w.drive_volts);
	endfunction

	task automatic log_fault(input string what, input out_t got, input out_t want);
		faults++;
		if (faults <= 10) begin
			$display("%s at %0t", what, $time);
			$display("  expected %s", show(want));
			$display("  actual   %s", show(got));
		end
	endtask

	task automatic offer(input logic [1:0] mode, input logic side, input logic [15:0] tilt,
			input logic [15:0] speed, input logic [23:0] demand);
		in_t w;
		w.mode = mode;
		w.side = side;
		w.tilt_angle = tilt;
		w.wheel_speed = speed;
		w.accel_demand = demand;
		feed.push_back(w);
		words_fed++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		REG_TILT_LIMIT: m_tilt_lim = longint'(val[14:0]);
		REG_ACCEL_LIMIT: m_accel_lim = longint'(val[22:0]);
		REG_ACCEL_GAIN: m_accel_gain = longint'(val);
		REG_SPEED_GAIN: m_speed_gain = longint'(val);
		REG_BUS_VOLTAGE: m_bus = longint'(val[15:0]);
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// all words taken, all results back, then let a late word finish
	task automatic drain();
		while (words_in != words_fed || drive_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		in_t w;
		int  pick, mag, lim;
		repeat (count) begin
			w.side = 1'($urandom);
			w.tilt_angle = 16'($urandom);
			w.wheel_speed = 16'($urandom);
			w.accel_demand = 24'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				w.mode = MODE_DEMAND;
				lim = int'(m_accel_lim);
				pick = $urandom_range(0, 3);
				case (pick)
				1: mag = $urandom_range(0, lim + 256);
				2: mag = $urandom_range(0, 4096);
				default: mag = lim + $urandom_range(0, 1);
				endcase
				if (mag > 8388608) mag = 8388608;
				if (pick != 0) w.accel_demand = 24'($urandom_range(0, 1) ? -mag : mag);
			end else if (pick < 65) begin
				w.mode = MODE_SPEED;
				if ($urandom_range(0, 1))
					w.wheel_speed = 16'($signed($urandom_range(0, 4096)) - 2048);
			end else if (pick < 95) begin
				w.mode = MODE_TILT;
				lim = int'(m_tilt_lim);
				case ($urandom_range(0, 3))
				0: mag = $urandom_range(0, 32768);
				1: mag = $urandom_range(0, lim);
				2: mag = $urandom_range(lim + 1, 32768);
				default: mag = lim + $urandom_range(0, 1);
				endcase
				w.tilt_angle = 16'($urandom_range(0, 1) ? -mag : mag);
			end else begin
				w.mode = MODE_SPARE;
			end
			feed.push_back(w);
			words_fed++;
		end
		drain();
	endtask

	// sender: bursts with gaps, payload held until taken
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (feed.size() != 0) begin
				in_data <= feed.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) burst_left--;
				else begin
					burst_left = $urandom_range(1, 60);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (words_in >= hold_at) begin
			// long hold-off: output register fills and the input stalls
			hold_at = words_in + $urandom_range(300, 700);
			stall_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				style = rx_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(20, 300);
			end else begin
				style_left--;
			end
			case (style)
			RX_FREE: out_ready <= 1'b1;
			RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default: begin
				stall_left = $urandom_range(2, 15);
				out_ready <= 1'b1;
			end
			endcase
		end
	end

	always @(posedge clk) begin : track
		out_t r, want;
		bit   out_took;
		in_took = (in_valid === 1'b1) && (in_ready === 1'b1);
		out_took = (out_valid === 1'b1) && (out_ready === 1'b1);
		if (in_took) begin
			words_in++;
			if (drive_response(in_data, r)) drive_due.push_back(r);
		end
		if (out_took) begin
			if (drive_due.size() == 0) begin
				log_fault("unexpected result word", out_data, '0);
			end else begin
				want = drive_due.pop_front();
				if (!words_match(out_data, want)) log_fault("result mismatch", out_data, want);
			end
		end
		if (!arst_n || in_took || out_took) stuck = 0;
		else stuck++;
		if (stuck >= STUCK_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TILT_LIMIT;
		cfg_wdata = '0;
		m_tilt_lim = longint'(RST_TILT_LIMIT);
		m_accel_lim = longint'(RST_ACCEL_LIMIT);
		m_accel_gain = longint'(RST_ACCEL_GAIN);
		m_speed_gain = longint'(RST_SPEED_GAIN);
		m_bus = longint'(RST_BUS_VOLTAGE);
		held_speed[0] = '0;
		held_speed[1] = '0;
		stopped = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero drive, tilt edges, stop and clear, clipping, bit patterns
		offer(MODE_DEMAND, 1'b0, 16'h0000, 16'h0000, 24'h000000);
		offer(MODE_TILT, 1'b0, 16'h0000, 16'h0000, 24'h000000);
		offer(MODE_TILT, 1'b1, 16'd5719, 16'h0000, 24'h000000);
		offer(MODE_TILT, 1'b0, -16'sd5719, 16'h0000, 24'h000000);
		offer(MODE_TILT, 1'b0, 16'd5720, 16'h0000, 24'h000000);
		offer(MODE_TILT, 1'b0, 16'h8000, 16'h0000, 24'h000000);
		offer(MODE_DEMAND, 1'b1, 16'h0000, 16'h0000, 24'h7FFFFF);
		offer(MODE_TILT, 1'b0, -16'sd5718, 16'h0000, 24'h000000);
		offer(MODE_SPEED, 1'b0, 16'h0000, 16'h7FFF, 24'h000000);
		offer(MODE_SPEED, 1'b1, 16'h0000, 16'h8000, 24'h000000);
		offer(MODE_DEMAND, 1'b0, 16'h0000, 16'h0000, 24'h7FFFFF);
		offer(MODE_DEMAND, 1'b1, 16'h0000, 16'h0000, 24'h800000);
		offer(MODE_DEMAND, 1'b0, 16'h0000, 16'h0000, 24'h000000);
		offer(MODE_DEMAND, 1'b1, 16'h0000, 16'h0000, 24'h000001);
		offer(MODE_SPARE, 1'b1, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		offer(MODE_SPEED, 1'b0, 16'hAAAA, 16'h5555, 24'hAAAAAA);
		offer(MODE_SPEED, 1'b1, 16'h5555, 16'hAAAA, 24'h555555);
		offer(MODE_DEMAND, 1'b0, 16'h5555, 16'hAAAA, 24'h555555);
		offer(MODE_DEMAND, 1'b1, 16'hAAAA, 16'h5555, 24'hAAAAAA);
		offer(MODE_SPEED, 1'b0, 16'h0000, 16'h0000, 24'h000000);
		offer(MODE_SPEED, 1'b1, 16'h0000, 16'h0000, 24'h000000);
		offer(MODE_DEMAND, 1'b0, 16'h0000, 16'h0000, 24'hFFFFFF);
		offer(MODE_TILT, 1'b1, 16'h7FFF, 16'h0000, 24'h000000);
		offer(MODE_TILT, 1'b0, 16'h0000, 16'h0000, 24'h000000);
		offer(MODE_DEMAND, 1'b1, 16'h0000, 16'h0000, 24'd128000);
		drain();

		random_phase(250);

		// upper extremes; reported voltage saturates here
		write_reg(REG_TILT_LIMIT, 32'h0000_7FFF);
		write_reg(REG_ACCEL_LIMIT, 32'h007F_FFFF);
		write_reg(REG_ACCEL_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_SPEED_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_BUS_VOLTAGE, 32'h0000_FFFF);
		random_phase(250);

		// lower extremes: any nonzero tilt stops, demand fully clipped
		write_reg(REG_TILT_LIMIT, 32'd0);
		write_reg(REG_ACCEL_LIMIT, 32'd0);
		write_reg(REG_ACCEL_GAIN, 32'd0);
		write_reg(REG_SPEED_GAIN, 32'd1);
		write_reg(REG_BUS_VOLTAGE, 32'd1);
		random_phase(200);

		// zero bus: clamp forces coasting
		write_reg(REG_TILT_LIMIT, $urandom);
		write_reg(REG_ACCEL_LIMIT, $urandom);
		write_reg(REG_ACCEL_GAIN, $urandom);
		write_reg(REG_SPEED_GAIN, $urandom);
		write_reg(REG_BUS_VOLTAGE, 32'd0);
		random_phase(150);

		repeat (3) begin
			write_reg(REG_TILT_LIMIT, $urandom);
			write_reg(REG_ACCEL_LIMIT, $urandom);
			write_reg(REG_ACCEL_GAIN, $urandom_range(0, 32'h003F_FFFF));
			write_reg(REG_SPEED_GAIN, $urandom);
			write_reg(REG_BUS_VOLTAGE, $urandom_range(1, 65535));
			random_phase(230);
		end

		if (faults == 0 && drive_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
